// File: rtl/keyframe_track_interpolator_defines.svh
// Assertion macros used by the interpolator top module.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define KTI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define KTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/kti_pkg.sv
package kti_pkg;

   localparam int MaxKeysDefault = 64;
   localparam int ValueWidth     = 16;
   localparam int TimeWidth      = 15;
   localparam int CountWidth     = 7;

   typedef enum logic [1:0] {
      OP_LOAD_POS = 2'd0,
      OP_LOAD_ROT = 2'd1,
      OP_EVAL     = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_POS_COUNT = 1'b0,
      CSR_ROT_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_ISSUE,
      ST_SCAN_CHECK,
      ST_PREV_ISSUE,
      ST_PREV_WAIT,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_TRACK_DONE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [5:0]         key_index;
      logic [14:0]        key_time;
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic signed [15:0] value_z;
      logic [14:0]        frame;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
   } rsp_type;

   typedef struct packed {
      logic [14:0]        time_val;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
   } key_type;

   // Request to the divider and its handshake.
   typedef struct packed {
      logic               start;
      logic signed [47:0] dividend;
      logic [15:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [47:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/keyframe_track_interpolator.sv
// Channel  Ports             Direction  Word
// req      req_valid/ready   in         req_type: load or evaluate
// rsp      rsp_valid/ready   out        rsp_type: position and rotation
// csr      csr_valid/ready   in         index, data: key counts
//
// A load is registered, then written to its key memory; no request is taken
// meanwhile. An evaluate scans each track key by key through the key memory
// read port; between two keys it runs the serial divider once per component.
// Reset is synchronous; key memories are not cleared, last results are.
// The result sits in its own register, so requests are taken while it waits;
// an evaluate that finishes while the previous word is still held waits for it.
`include "keyframe_track_interpolator_defines.svh"
module keyframe_track_interpolator
   import kti_pkg::*;
#(
   parameter int MAX_KEYS = MaxKeysDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [6:0]      csr_data
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);

   state_type state_ff, state_in;
   logic [6:0] pos_cnt_ff, rot_cnt_ff;
   logic       track_ff, track_in;        // 0 position, 1 rotation
   logic [AW:0] k_ff, k_in;
   logic [NW-1:0] n_eff;
   logic [1:0] comp_ff, comp_in;
   logic [14:0] frame_ff;
   key_type    cur_ff, cur_in;
   key_type    prev_ff, prev_in;
   logic signed [15:0] res_ff [6];
   logic signed [15:0] res_in [6];
   logic [2:0] res_base;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       load_ff;
   req_type    req_hold_ff;
   logic [AW-1:0] rd_addr;
   key_type    pos_rd, rot_rd, rd_key;
   key_type    wr_key;
   logic       pos_we, rot_we;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic       accept;
   logic [6:0] cnt_sel;
   logic signed [15:0] cur_c, prev_c, d_c;
   logic [15:0] span;
   logic [15:0] elapsed;
   logic signed [32:0] de;
   logic signed [32:0] prev_span;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign res_base  = track_ff ? 3'd3 : 3'd0;

   assign wr_key = '{req_hold_ff.key_time, req_hold_ff.value_x, req_hold_ff.value_y,
                     req_hold_ff.value_z};
   assign pos_we = load_ff && req_hold_ff.opcode == OP_LOAD_POS
                   && 32'(req_hold_ff.key_index) < MAX_KEYS;
   assign rot_we = load_ff && req_hold_ff.opcode == OP_LOAD_ROT
                   && 32'(req_hold_ff.key_index) < MAX_KEYS;

   kti_key_mem #(.MAX_KEYS(MAX_KEYS)) u_pos_mem (
      .clock(clock), .wr_en(pos_we), .wr_addr(AW'(req_hold_ff.key_index)),
      .wr_data(wr_key), .rd_addr(rd_addr), .rd_data(pos_rd));
   kti_key_mem #(.MAX_KEYS(MAX_KEYS)) u_rot_mem (
      .clock(clock), .wr_en(rot_we), .wr_addr(AW'(req_hold_ff.key_index)),
      .wr_data(wr_key), .rd_addr(rd_addr), .rd_data(rot_rd));
   kti_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign rd_key  = track_ff ? rot_rd : pos_rd;
   assign cnt_sel = track_ff ? rot_cnt_ff : pos_cnt_ff;
   assign n_eff   = (32'(cnt_sel) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(cnt_sel);
   assign req_ready = state_ff == ST_IDLE && !load_ff;

   always_comb begin
      unique case (comp_ff)
         2'd0:    begin cur_c = cur_ff.vx; prev_c = prev_ff.vx; end
         2'd1:    begin cur_c = cur_ff.vy; prev_c = prev_ff.vy; end
         default: begin cur_c = cur_ff.vz; prev_c = prev_ff.vz; end
      endcase
   end
   assign d_c       = cur_c - prev_c;
   assign span      = {1'b0, cur_ff.time_val} - {1'b0, prev_ff.time_val};
   assign elapsed   = {1'b0, frame_ff} - {1'b0, prev_ff.time_val};
   assign de        = d_c * $signed({1'b0, elapsed});
   assign prev_span = prev_c * $signed({1'b0, span});

   always_comb begin
      div_req.start    = state_ff == ST_DIV_START;
      div_req.divisor  = span;
      div_req.dividend = track_ff
                         ? 48'(de) + 48'(prev_span)
                         : 48'(de);
      rd_addr = k_ff[AW-1:0];
      if (state_ff == ST_PREV_ISSUE) begin
         rd_addr = AW'(k_ff - 1'b1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.opcode == OP_EVAL) begin
               state_in = ST_SCAN_ISSUE;
            end
         end
         ST_SCAN_ISSUE: begin
            if (n_eff == '0 || {1'b0, k_ff} >= (AW + 2)'(n_eff)) begin
               state_in = ST_TRACK_DONE;
            end else begin
               state_in = ST_SCAN_CHECK;
            end
         end
         ST_SCAN_CHECK: begin
            if (n_eff == NW'(1) || frame_ff == rd_key.time_val
                || (frame_ff < rd_key.time_val && k_ff == '0)) begin
               state_in = ST_TRACK_DONE;
            end else if (frame_ff < rd_key.time_val) begin
               state_in = ST_PREV_ISSUE;
            end else begin
               state_in = ST_SCAN_ISSUE;
            end
         end
         ST_PREV_ISSUE: state_in = ST_PREV_WAIT;
         ST_PREV_WAIT:  state_in = ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (div_rsp.done) begin
               state_in = (comp_ff == 2'd2) ? ST_TRACK_DONE : ST_DIV_START;
            end
         end
         ST_TRACK_DONE: state_in = track_ff ? ST_OUTPUT : ST_SCAN_ISSUE;
         ST_OUTPUT:     state_in = out_free ? ST_IDLE : ST_OUTPUT;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      track_in     = track_ff;
      k_in         = k_ff;
      comp_in      = comp_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            track_in = 1'b0;
            k_in     = '0;
         end
         ST_SCAN_CHECK: begin
            cur_in = rd_key;
            k_in   = k_ff + 1'b1;
            if (n_eff == NW'(1) || frame_ff == rd_key.time_val
                || (frame_ff < rd_key.time_val && k_ff == '0)) begin
               res_in[res_base]        = rd_key.vx;
               res_in[res_base + 3'd1] = rd_key.vy;
               res_in[res_base + 3'd2] = rd_key.vz;
            end else if (frame_ff < rd_key.time_val) begin
               k_in = k_ff;
            end
         end
         ST_PREV_WAIT: begin
            prev_in = rd_key;
            comp_in = 2'd0;
         end
         ST_DIV_RUN: begin
            if (div_rsp.done) begin
               res_in[res_base + {1'b0, comp_ff}] = track_ff
                  ? div_rsp.quotient[15:0] : prev_c + div_rsp.quotient[15:0];
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_TRACK_DONE: begin
            track_in = 1'b1;
            k_in     = '0;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{res_ff[0], res_ff[1], res_ff[2],
                                res_ff[3], res_ff[4], res_ff[5]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         load_ff      <= 1'b0;
         pos_cnt_ff   <= '0;
         rot_cnt_ff   <= '0;
         for (int i = 0; i < 6; i++) res_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         load_ff      <= accept && (req_data.opcode == OP_LOAD_POS
                                    || req_data.opcode == OP_LOAD_ROT);
         res_ff       <= res_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POS_COUNT) pos_cnt_ff <= csr_data;
            else                            rot_cnt_ff <= csr_data;
         end
      end
      track_ff <= track_in;
      k_ff     <= k_in;
      comp_ff  <= comp_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      if (accept) begin
         req_hold_ff <= req_data;
         frame_ff    <= req_data.frame;
      end
   end

   `KTI_ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_ready, "busy")
   `KTI_ASSERT_NEXT(a_out_after_eval, clock, reset, state_ff == ST_OUTPUT, rsp_valid, "no result")
   `KTI_ASSERT_IMPLY(a_no_div_idle, clock, reset, state_ff == ST_IDLE, !div_rsp.done, "divider")

endmodule

// File: rtl/kti_key_mem.sv
module kti_key_mem
   import kti_pkg::*;
#(
   parameter int MAX_KEYS = MaxKeysDefault
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_KEYS)-1:0] wr_addr,
   input  key_type                     wr_data,
   input  logic [$clog2(MAX_KEYS)-1:0] rd_addr,
   output key_type                     rd_data
);

   key_type mem [MAX_KEYS];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/kti_divider.sv
module kti_divider
   import kti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // Signed 48-bit by unsigned 16-bit restoring divide, one quotient bit a cycle,
   // truncating toward zero.
   logic [47:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;
   logic [16:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[15:0], quo_ff[47]};
      diff    = shifted - {1'b0, den_ff};
      if (div_req.start) begin
         neg_in  = div_req.dividend[47];
         quo_in  = div_req.dividend[47] ? 48'(-div_req.dividend) : div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff;
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? 48'(-quo_ff) : quo_ff;

endmodule

// File: dv/kti_checker.sv
module kti_checker
   import kti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_index,
   input  logic [6:0] csr_data,
   output int      mismatches,
   output int      frames_pending,
   output int      frames_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumKeys = MaxKeysDefault;

   // Track 0 is position, track 1 is rotation.
   logic [14:0]  key_time_mem [2][NumKeys];
   shortint      key_val_mem  [2][NumKeys][3];
   shortint      held_result  [2][3];
   int           key_count    [2];
   rsp_type      expected_frames[$];

   assign frames_pending = expected_frames.size();

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic void interpolate_track(int trk, int frame);
      int     n;
      longint s;
      longint e;
      longint prev;
      longint d;
      int     tk;
      n = (key_count[trk] > NumKeys) ? NumKeys : key_count[trk];
      if (n == 0) return;
      if (n == 1) begin
         for (int c = 0; c < 3; c++) held_result[trk][c] = key_val_mem[trk][0][c];
         return;
      end
      for (int k = 0; k < n; k++) begin
         tk = int'(key_time_mem[trk][k]);
         if (frame < tk) begin
            if (k == 0) begin
               for (int c = 0; c < 3; c++) held_result[trk][c] = key_val_mem[trk][0][c];
               return;
            end
            s = tk - longint'(key_time_mem[trk][k-1]);
            e = frame - longint'(key_time_mem[trk][k-1]);
            // The scan cannot get here with a non-positive span, but stay safe.
            if (s <= 0) begin
               for (int c = 0; c < 3; c++) held_result[trk][c] = key_val_mem[trk][k][c];
               return;
            end
            for (int c = 0; c < 3; c++) begin
               prev = longint'(key_val_mem[trk][k-1][c]);
               d = longint'(shortint'(longint'(key_val_mem[trk][k][c]) - prev));
               if (trk == 1) held_result[trk][c] = shortint'((prev * s + d * e) / s);
               else          held_result[trk][c] = shortint'(prev + (d * e) / s);
            end
            return;
         end
         if (frame == tk) begin
            for (int c = 0; c < 3; c++) held_result[trk][c] = key_val_mem[trk][k][c];
            return;
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      trk;
      if (reset) begin
         for (int t = 0; t < 2; t++) begin
            key_count[t] = 0;
            for (int c = 0; c < 3; c++) held_result[t][c] = 0;
         end
         expected_frames.delete();
         mismatches = 0;
         frames_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POS_COUNT) key_count[0] = int'(csr_data);
            else                            key_count[1] = int'(csr_data);
         end
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_LOAD_POS || req_data.opcode == OP_LOAD_ROT) begin
               trk = int'(req_data.opcode == OP_LOAD_ROT);
               key_time_mem[trk][req_data.key_index] = req_data.key_time;
               key_val_mem[trk][req_data.key_index][0] = req_data.value_x;
               key_val_mem[trk][req_data.key_index][1] = req_data.value_y;
               key_val_mem[trk][req_data.key_index][2] = req_data.value_z;
            end else if (req_data.opcode == OP_EVAL) begin
               interpolate_track(0, int'(req_data.frame));
               interpolate_track(1, int'(req_data.frame));
               want.pos_x = held_result[0][0];
               want.pos_y = held_result[0][1];
               want.pos_z = held_result[0][2];
               want.rot_x = held_result[1][0];
               want.rot_y = held_result[1][1];
               want.rot_z = held_result[1][2];
               expected_frames.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch("result count", frames_checked + 1, frames_checked);
            end else begin
               want = expected_frames.pop_front();
               frames_checked++;
               if (rsp_data.pos_x !== want.pos_x) report_mismatch("pos_x", rsp_data.pos_x, want.pos_x);
               if (rsp_data.pos_y !== want.pos_y) report_mismatch("pos_y", rsp_data.pos_y, want.pos_y);
               if (rsp_data.pos_z !== want.pos_z) report_mismatch("pos_z", rsp_data.pos_z, want.pos_z);
               if (rsp_data.rot_x !== want.rot_x) report_mismatch("rot_x", rsp_data.rot_x, want.rot_x);
               if (rsp_data.rot_y !== want.rot_y) report_mismatch("rot_y", rsp_data.rot_y, want.rot_y);
               if (rsp_data.rot_z !== want.rot_z) report_mismatch("rot_z", rsp_data.rot_z, want.rot_z);
            end
         end
      end
   end

endmodule

// File: dv/tb_top.sv
module tb_top
   import kti_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 3000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_POS_COUNT;
   logic [6:0] csr_data = '0;

   int mismatches;
   int frames_pending;
   int frames_checked;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic [14:0] pos_times [64];

   always #5 clock = ~clock;

   keyframe_track_interpolator u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   kti_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches, .frames_pending, .frames_checked
   );

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_word(req_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Let all expected results drain and the last load finish before touching the key counts.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_count(csr_index_type idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[6:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_counts(int pos_count, int rot_count);
      drain();
      write_count(CSR_POS_COUNT, pos_count);
      write_count(CSR_ROT_COUNT, rot_count);
   endtask

   task automatic load_key(opcode_type op, int slot, int key_t, int vx, int vy, int vz);
      req_type w;
      w = '0;
      w.opcode    = op;
      w.key_index = slot[5:0];
      w.key_time  = key_t[14:0];
      w.value_x   = vx[15:0];
      w.value_y   = vy[15:0];
      w.value_z   = vz[15:0];
      w.frame     = 15'($urandom);
      if (op == OP_LOAD_POS) pos_times[slot] = key_t[14:0];
      send_word(w);
   endtask

   task automatic eval_frame(int frame);
      req_type w;
      w = req_type'({$urandom, $urandom, $urandom});
      w.opcode = OP_EVAL;
      w.frame  = frame[14:0];
      send_word(w);
   endtask

   // Ascending times with random values; the first two slots take the value extremes.
   task automatic fill_track(opcode_type op);
      for (int i = 0; i < 64; i++) begin
         if (i == 0)      load_key(op, i, 100 + $urandom_range(399), 32767, -32768, 0);
         else if (i == 1) load_key(op, i, 600 + $urandom_range(499), -32768, 32767, -1);
         else load_key(op, i, 100 + i * 500 + $urandom_range(499), $urandom, $urandom, $urandom);
      end
   endtask

   function automatic int pick_count();
      case ($urandom_range(7))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 64;
         4: return $urandom_range(127, 65);
         default: return $urandom_range(63, 3);
      endcase
   endfunction

   task automatic random_item();
      req_type w;
      int      sel;
      int      slot;
      sel = $urandom_range(99);
      slot = $urandom_range(63);
      if (sel < 58) begin
         if ($urandom_range(1)) eval_frame($urandom_range(32767));
         else eval_frame(int'(pos_times[slot]) + $urandom_range(2) - 1);
      end else if (sel < 95) begin
         // Mostly keep each track ascending; now and then break the order.
         if ($urandom_range(4) == 0)
            load_key(sel[0] ? OP_LOAD_ROT : OP_LOAD_POS, slot, $urandom_range(32767),
                     $urandom, $urandom, $urandom);
         else
            load_key(sel[0] ? OP_LOAD_ROT : OP_LOAD_POS, slot,
                     100 + slot * 500 + $urandom_range(499), $urandom, $urandom, $urandom);
      end else begin
         w = req_type'({$urandom, $urandom, $urandom});
         w.opcode = OP_NONE;
         w.key_index = 6'($urandom);
         w.key_time = 15'($urandom);
         send_word(w);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty tracks hold zero, and an unused opcode does nothing.
      eval_frame(0);
      eval_frame(32767);
      begin
         req_type w;
         w = '1;
         w.opcode = OP_NONE;
         send_word(w);
      end
      load_key(OP_LOAD_POS, 0, 32767, -32768, 32767, 12345);
      load_key(OP_LOAD_ROT, 0, 0, 32767, -32768, -12345);
      set_counts(1, 1);
      eval_frame(0);
      eval_frame(32767);
      fill_track(OP_LOAD_POS);
      fill_track(OP_LOAD_ROT);
      set_counts(64, 64);
      eval_frame(0);
      eval_frame(int'(pos_times[0]));
      eval_frame(int'(pos_times[1]));
      eval_frame(int'(pos_times[0]) + 1 + (int'(pos_times[1]) - int'(pos_times[0])) / 2);
      eval_frame(int'(pos_times[63]) - 1);
      eval_frame(int'(pos_times[63]));
      eval_frame(32767);
      set_counts(127, 2);
      eval_frame(int'(pos_times[1]) - 1);
      eval_frame(32767);
      set_counts(0, 65);
      eval_frame(int'(pos_times[40]));

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
         recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 31 : 0;
         for (int n = 0; n < 100; n++) begin
            if (n % 50 == 0) set_counts(pick_count(), pick_count());
            random_item();
         end
      end
      set_counts(64, 64);
      eval_frame(int'(pos_times[63]));

      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("Covered empty, single-key and full tracks, counts past the key limit, exact");
      $display("and interpolated frames, and %0d checked results under random stalls.",
               frames_checked);
      if (mismatches == 0 && frames_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/kti_pkg.sv
rtl/kti_key_mem.sv
rtl/kti_divider.sv
rtl/keyframe_track_interpolator.sv
dv/kti_checker.sv
dv/tb_top.sv
